FILE: sv/pfcst_pkg.sv
package pfcst_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    V_FULL   = 3'd0,
    V_AHEAD  = 3'd1,
    V_ACCEPT = 3'd2,
    V_LAST   = 3'd3,
    V_DUP    = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } back_state_e;

  typedef struct packed {
    logic [31:0]        ip;
    logic [15:0]        port;
    logic signed [31:0] chunk;
    logic               last;
  } item_t;

  // Low three bits of a slot number, zero-extended when the index is narrower.
  function automatic logic [2:0] to_slot_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

endpackage

FILE: sv/pfcst_front.sv
module pfcst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfcst_pkg::item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pfcst_pkg::item_t item_o
);

  localparam logic [pfcst_pkg::QPTR_W-1:0] PtrLast = pfcst_pkg::QPTR_W'(pfcst_pkg::QDEPTH - 1);
  localparam logic [pfcst_pkg::QCNT_W-1:0] CntFull = pfcst_pkg::QCNT_W'(pfcst_pkg::QDEPTH);

  pfcst_pkg::item_t                  mem_q [pfcst_pkg::QDEPTH];
  logic [pfcst_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pfcst_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pfcst_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: sv/pfcst_back.sv
module pfcst_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  pfcst_pkg::item_t q_item_i,
  output logic             q_pop_o,
  output logic             done_o,
  output logic [2:0]       verdict_o,
  output logic             send_ack_o,
  output logic [2:0]       slot_index_o
);

  localparam int unsigned IW = pfcst_pkg::IDX_W;
  localparam logic [IW-1:0] IdxLast = IW'(pfcst_pkg::SLOTS - 1);

  pfcst_pkg::back_state_e state_q, state_d;
  pfcst_pkg::item_t       item_q;

  logic [31:0] ip_mem   [pfcst_pkg::SLOTS];
  logic [15:0] port_mem [pfcst_pkg::SLOTS];
  logic [31:0] cnt_mem  [pfcst_pkg::SLOTS];
  logic [31:0] rd_ip_q;
  logic [15:0] rd_port_q;
  logic [31:0] rd_cnt_q;

  logic [pfcst_pkg::SLOTS-1:0] free_q, free_d;
  logic [IW-1:0] issue_q, issue_d;
  logic          issue_done_q, issue_done_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q;
  logic [IW-1:0] spare_q, spare_d, spare_nx;
  logic          spare_vld_q, spare_vld_d, spare_vld_nx;
  logic [IW-1:0] slot_q, slot_d;
  logic [31:0]   count_q, count_d;
  logic          claim_q, claim_d;
  logic          found_q, found_d;

  logic          hit, scan_end, cmp_free;
  logic [32:0]   next33, chunk33;
  logic          ahead, equal;

  logic          wr_en;
  logic [31:0]   wr_cnt;
  pfcst_pkg::verdict_e res_verdict;
  logic          res_ack;
  logic [2:0]    res_slot;

  logic          done_q;
  logic [2:0]    verdict_q;
  logic          ack_q;
  logic [2:0]    slot_idx_q;

  assign cmp_free = free_q[cmp_idx_q];
  assign hit      = cmp_vld_q && !cmp_free && (rd_ip_q == item_q.ip)
                    && (rd_port_q == item_q.port);
  assign scan_end = cmp_vld_q && (hit || (cmp_idx_q == IdxLast));
  assign spare_vld_nx = spare_vld_q || (cmp_vld_q && cmp_free);
  assign spare_nx     = (cmp_vld_q && cmp_free) ? cmp_idx_q : spare_q;

  // Compare against count+1 in 33-bit signed arithmetic.
  assign next33  = {count_q[31], count_q} + 33'd1;
  assign chunk33 = {item_q.chunk[31], item_q.chunk};
  assign ahead   = $signed(chunk33) > $signed(next33);
  assign equal   = (chunk33 == next33);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfcst_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = pfcst_pkg::ST_SCAN;
      end
      pfcst_pkg::ST_SCAN: begin
        if (scan_end) state_d = pfcst_pkg::ST_DECIDE;
      end
      pfcst_pkg::ST_DECIDE: state_d = pfcst_pkg::ST_IDLE;
      default:              state_d = pfcst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_cnt      = '0;
    res_verdict = pfcst_pkg::V_FULL;
    res_ack     = 1'b0;
    res_slot    = '0;
    case (state_q)
      pfcst_pkg::ST_IDLE: q_pop_o = q_valid_i;
      pfcst_pkg::ST_SCAN: ;
      pfcst_pkg::ST_DECIDE: begin
        if (found_q) begin
          res_slot = pfcst_pkg::to_slot_index(slot_q);
          if (ahead) begin
            res_verdict = pfcst_pkg::V_AHEAD;
          end else if (equal) begin
            res_verdict = item_q.last ? pfcst_pkg::V_LAST : pfcst_pkg::V_ACCEPT;
            res_ack     = 1'b1;
          end else begin
            res_verdict = pfcst_pkg::V_DUP;
            res_ack     = 1'b1;
          end
          wr_en  = claim_q || equal;
          wr_cnt = equal ? next33[31:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // Scan bookkeeping
  always_comb begin
    issue_d      = issue_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = (state_q == pfcst_pkg::ST_SCAN) && !issue_done_q;
    spare_d      = spare_q;
    spare_vld_d  = spare_vld_q;
    slot_d       = slot_q;
    count_d      = count_q;
    claim_d      = claim_q;
    found_d      = found_q;
    free_d       = free_q;
    if (state_q == pfcst_pkg::ST_IDLE) begin
      issue_d      = '0;
      issue_done_d = 1'b0;
      spare_vld_d  = 1'b0;
    end
    if (state_q == pfcst_pkg::ST_SCAN) begin
      if (!issue_done_q) begin
        issue_d      = (issue_q == IdxLast) ? issue_q : issue_q + 1'b1;
        issue_done_d = (issue_q == IdxLast);
      end
      if (cmp_vld_q) begin
        spare_d     = spare_nx;
        spare_vld_d = spare_vld_nx;
      end
      if (scan_end) begin
        found_d = hit || spare_vld_nx;
        slot_d  = hit ? cmp_idx_q : spare_nx;
        count_d = hit ? rd_cnt_q : '0;
        claim_d = !hit;
      end
    end
    if (state_q == pfcst_pkg::ST_DECIDE && found_q) begin
      if (equal && item_q.last) begin
        free_d[slot_q] = 1'b1;
      end else if (claim_q) begin
        free_d[slot_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfcst_pkg::ST_IDLE;
      free_q       <= '1;
      issue_q      <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      spare_vld_q  <= 1'b0;
      found_q      <= 1'b0;
      claim_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_q       <= free_d;
      issue_q      <= issue_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      spare_vld_q  <= spare_vld_d;
      found_q      <= found_d;
      claim_q      <= claim_d;
      done_q       <= (state_q == pfcst_pkg::ST_DECIDE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    cmp_idx_q  <= issue_q;
    spare_q    <= spare_d;
    slot_q     <= slot_d;
    count_q    <= count_d;
    verdict_q  <= res_verdict;
    ack_q      <= res_ack;
    slot_idx_q <= res_slot;
  end

  // Slot tables: one read port on the scan index, one write port on the chosen slot
  always_ff @(posedge clk_i) begin
    rd_ip_q   <= ip_mem[issue_q];
    rd_port_q <= port_mem[issue_q];
    rd_cnt_q  <= cnt_mem[issue_q];
    if (wr_en) begin
      ip_mem[slot_q]   <= item_q.ip;
      port_mem[slot_q] <= item_q.port;
      cnt_mem[slot_q]  <= wr_cnt;
    end
  end

  assign done_o       = done_q;
  assign verdict_o    = verdict_q;
  assign send_ack_o   = ack_q;
  assign slot_index_o = slot_idx_q;

endmodule

FILE: sv/per_flow_chunk_sequence_tracker.sv
// Channel   Direction  Handshake              Fields
// header    in         start / busy           source_ip_i, source_port_i, chunk_number_i, is_last_i
// result    out        done_o strobe, 1 cycle  verdict_o, send_ack_o, slot_index_o
//
// In the back end a header is loaded from the queue, the table is scanned slot by slot
// through the registered read port, and the verdict is decided and the slot written back.
// A hit ends the scan early. A two-entry queue takes headers while the back end works;
// busy is high only while that queue is full. Reset frees all slots at once.
// The result register is shown for one cycle; the receiver cannot stall it.
module per_flow_chunk_sequence_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_ip_i,
  input  logic [15:0] source_port_i,
  input  logic signed [31:0] chunk_number_i,
  input  logic        is_last_i,
  output logic        done_o,
  output logic [2:0]  verdict_o,
  output logic        send_ack_o,
  output logic [2:0]  slot_index_o
);

  pfcst_pkg::item_t in_item;
  pfcst_pkg::item_t q_item;
  logic             q_valid;
  logic             q_pop;

  assign in_item.ip    = source_ip_i;
  assign in_item.port  = source_port_i;
  assign in_item.chunk = chunk_number_i;
  assign in_item.last  = is_last_i;

  pfcst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .push_item_i (in_item),
    .full_o      (busy),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  pfcst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .done_o       (done_o),
    .verdict_o    (verdict_o),
    .send_ack_o   (send_ack_o),
    .slot_index_o (slot_index_o)
  );

endmodule

FILE: sv/pfcst_checker.sv
module pfcst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  verdict_o,
  input logic        send_ack_o,
  input logic [2:0]  slot_index_o
);

  // A full table reports no slot and no acknowledgement.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (verdict_o == pfcst_pkg::V_FULL) |-> (slot_index_o == 3'd0) && !send_ack_o)
    else $error("table-full result carries a slot or an ack");

  // Ack goes out exactly for accepted and duplicate chunks.
  a_ack_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> send_ack_o == ((verdict_o == pfcst_pkg::V_ACCEPT)
                           || (verdict_o == pfcst_pkg::V_LAST)
                           || (verdict_o == pfcst_pkg::V_DUP)))
    else $error("send_ack disagrees with verdict");

  // Two results never come back to back.
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  // Nothing can be reported in the cycle right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o && !busy)
    else $error("activity right after reset");

endmodule

bind per_flow_chunk_sequence_tracker pfcst_checker u_pfcst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .done_o       (done_o),
  .verdict_o    (verdict_o),
  .send_ack_o   (send_ack_o),
  .slot_index_o (slot_index_o)
);
